// ===== hw/rtl/ispa_pkg.sv =====
// ----------------------------------------------------------------------------
// ispa_pkg
// Shared types, constants and Q12.20 arithmetic helpers for the stencil
// preconditioner apply block.
// ----------------------------------------------------------------------------
package ispa_pkg;

	localparam int DW     = 32;
	localparam int FRAC   = 20;
	localparam int DIM    = 16;
	localparam int CW     = $clog2(DIM);
	localparam int SZW    = CW + 1;
	localparam int IDXW   = 3 * CW;
	localparam int NPTS   = DIM * DIM * DIM;
	localparam int NSTORE = 12;
	localparam int STW    = 4;
	localparam int MAW    = STW + IDXW;
	localparam int MDEPTH = NSTORE * NPTS;
	localparam int QW     = 2 * FRAC + 1;
	localparam int QCW    = $clog2(QW);
	localparam int NLD    = 8;
	localparam int PCW    = 5;

	typedef logic signed [DW-1:0] word_t;
	typedef logic [IDXW-1:0]      idx_t;
	typedef logic [MAW-1:0]       maddr_t;
	typedef logic [CW-1:0]        coord_t;
	typedef logic [SZW-1:0]       size_t_t;

	localparam word_t VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam word_t VMIN = {1'b1, {(DW-1){1'b0}}};
	localparam size_t_t DIM_SZ = SZW'(DIM);

	typedef enum logic [STW-1:0] {
		ST_WEST, ST_SOUTH, ST_DOWN, ST_DIAG, ST_EAST, ST_NORTH, ST_UP,
		ST_RHS, ST_RECIP, ST_Y, ST_RESID, ST_Z
	} store_t;

	typedef enum logic [1:0] {OPC_LOAD, OPC_SOLVE, OPC_READ} opc_t;

	typedef enum logic [1:0] {CFG_SWEEP, CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z} cfg_reg_t;

	typedef enum logic [3:0] {
		AO_NOP, AO_LDA, AO_SUBA, AO_LDB, AO_MULB, AO_SUBB, AO_ADDB, AO_BSUBA,
		AO_CLRA, AO_WR
	} alu_op_t;

	typedef enum logic [2:0] {DIR_SELF, DIR_W, DIR_S, DIR_D, DIR_E, DIR_N, DIR_U} dir_t;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_LOAD, S_DIVW, S_READ, S_ISSUE, S_EXEC, S_FIN
	} state_t;

	typedef struct packed {
		alu_op_t op;
		store_t  st;
		logic    nb;
		dir_t    grp;
		logic    last;
	} uop_t;

	typedef struct packed {
		logic    we;
		maddr_t  waddr;
		word_t   wdata;
		maddr_t  raddr;
	} mem_req_t;

	typedef struct packed {
		logic    en;
		alu_op_t op;
	} alu_ctrl_t;

	function automatic word_t qadd(word_t a, word_t b);
		logic [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
		return word_t'(s[DW-1:0]);
	endfunction

	function automatic word_t qsub(word_t a, word_t b);
		logic [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
		return word_t'(s[DW-1:0]);
	endfunction

	// exact product, floor shift by FRAC, saturate
	function automatic word_t qmul(word_t a, word_t b);
		logic signed [2*DW-1:0]    p;
		logic [2*DW-FRAC-1:0]      s;
		logic [2*DW-FRAC-DW:0]     hi;
		p  = a * b;
		s  = p[2*DW-1:FRAC];
		hi = s[2*DW-FRAC-1:DW-1];
		if ((&hi) || !(|hi)) return word_t'(s[DW-1:0]);
		return s[2*DW-FRAC-1] ? VMIN : VMAX;
	endfunction

	function automatic uop_t mk(alu_op_t op, store_t st, logic nb, dir_t grp, logic last);
		uop_t u;
		u.op   = op;
		u.st   = st;
		u.nb   = nb;
		u.grp  = grp;
		u.last = last;
		return u;
	endfunction

	function automatic store_t dir_coef(dir_t d);
		store_t s;
		unique case (d)
			DIR_W:   s = ST_WEST;
			DIR_S:   s = ST_SOUTH;
			DIR_D:   s = ST_DOWN;
			DIR_E:   s = ST_EAST;
			DIR_N:   s = ST_NORTH;
			DIR_U:   s = ST_UP;
			default: s = ST_DIAG;
		endcase
		return s;
	endfunction

	// coef * v[nb] * recip[nb], folded into acc by fin
	function automatic uop_t term4(logic [3:0] g, logic upper, store_t vst, alu_op_t fin);
		dir_t d;
		uop_t u;
		case (g[3:2])
			2'd0:    d = upper ? DIR_E : DIR_W;
			2'd1:    d = upper ? DIR_N : DIR_S;
			default: d = upper ? DIR_U : DIR_D;
		endcase
		case (g[1:0])
			2'd0:    u = mk(AO_LDB, dir_coef(d), 1'b0, d, 1'b0);
			2'd1:    u = mk(AO_MULB, vst, 1'b1, d, 1'b0);
			2'd2:    u = mk(AO_MULB, ST_RECIP, 1'b1, d, 1'b0);
			default: u = mk(fin, ST_Y, 1'b0, d, 1'b0);
		endcase
		return u;
	endfunction

	// micro-program of one point; kind = {upper, pass}
	function automatic uop_t uprog(logic [1:0] kind, logic [PCW-1:0] pc);
		uop_t u;
		logic [PCW-1:0] g;
		u = mk(AO_NOP, ST_Y, 1'b0, DIR_SELF, 1'b0);
		g = '0;
		case (kind)
			2'b00: begin
				case (pc) inside
					5'd0:      u = mk(AO_LDA, ST_RHS, 1'b0, DIR_SELF, 1'b0);
					5'd1:      u = mk(AO_SUBA, ST_Y, 1'b0, DIR_SELF, 1'b0);
					[5'd2:5'd13]: begin
						g = pc - 5'd2;
						u = term4(g[3:0], 1'b0, ST_Y, AO_SUBB);
					end
					5'd14:     u = mk(AO_WR, ST_RESID, 1'b0, DIR_SELF, 1'b1);
					default:   u = mk(AO_NOP, ST_Y, 1'b0, DIR_SELF, 1'b0);
				endcase
			end
			2'b01: begin
				case (pc) inside
					5'd0:      u = mk(AO_LDA, ST_RESID, 1'b0, DIR_SELF, 1'b0);
					[5'd2:5'd13]: begin
						g = pc - 5'd2;
						u = term4(g[3:0], 1'b0, ST_RESID, AO_SUBB);
					end
					5'd14:     u = mk(AO_LDB, ST_Y, 1'b0, DIR_SELF, 1'b0);
					5'd15:     u = mk(AO_ADDB, ST_Y, 1'b0, DIR_SELF, 1'b0);
					5'd16:     u = mk(AO_WR, ST_Y, 1'b0, DIR_SELF, 1'b1);
					default:   u = mk(AO_NOP, ST_Y, 1'b0, DIR_SELF, 1'b0);
				endcase
			end
			2'b10: begin
				case (pc)
					5'd0:    u = mk(AO_LDA, ST_Y, 1'b0, DIR_SELF, 1'b0);
					5'd1:    u = mk(AO_LDB, ST_Z, 1'b0, DIR_SELF, 1'b0);
					5'd2:    u = mk(AO_MULB, ST_DIAG, 1'b0, DIR_SELF, 1'b0);
					5'd3:    u = mk(AO_SUBB, ST_Y, 1'b0, DIR_SELF, 1'b0);
					5'd4:    u = mk(AO_LDB, ST_EAST, 1'b0, DIR_E, 1'b0);
					5'd5:    u = mk(AO_MULB, ST_Z, 1'b1, DIR_E, 1'b0);
					5'd6:    u = mk(AO_SUBB, ST_Y, 1'b0, DIR_E, 1'b0);
					5'd7:    u = mk(AO_LDB, ST_NORTH, 1'b0, DIR_N, 1'b0);
					5'd8:    u = mk(AO_MULB, ST_Z, 1'b1, DIR_N, 1'b0);
					5'd9:    u = mk(AO_SUBB, ST_Y, 1'b0, DIR_N, 1'b0);
					5'd10:   u = mk(AO_LDB, ST_UP, 1'b0, DIR_U, 1'b0);
					5'd11:   u = mk(AO_MULB, ST_Z, 1'b1, DIR_U, 1'b0);
					5'd12:   u = mk(AO_SUBB, ST_Y, 1'b0, DIR_U, 1'b0);
					5'd13:   u = mk(AO_WR, ST_RESID, 1'b0, DIR_SELF, 1'b1);
					default: u = mk(AO_NOP, ST_Y, 1'b0, DIR_SELF, 1'b0);
				endcase
			end
			default: begin
				case (pc) inside
					5'd0:      u = mk(AO_CLRA, ST_Y, 1'b0, DIR_SELF, 1'b0);
					[5'd1:5'd12]: begin
						g = pc - 5'd1;
						u = term4(g[3:0], 1'b1, ST_RESID, AO_ADDB);
					end
					5'd13:     u = mk(AO_LDB, ST_RESID, 1'b0, DIR_SELF, 1'b0);
					5'd14:     u = mk(AO_BSUBA, ST_Y, 1'b0, DIR_SELF, 1'b0);
					5'd15:     u = mk(AO_MULB, ST_RECIP, 1'b0, DIR_SELF, 1'b0);
					5'd16:     u = mk(AO_LDA, ST_Z, 1'b0, DIR_SELF, 1'b0);
					5'd17:     u = mk(AO_ADDB, ST_Y, 1'b0, DIR_SELF, 1'b0);
					5'd18:     u = mk(AO_WR, ST_Z, 1'b0, DIR_SELF, 1'b1);
					default:   u = mk(AO_NOP, ST_Y, 1'b0, DIR_SELF, 1'b0);
				endcase
			end
		endcase
		return u;
	endfunction

endpackage

// ===== hw/rtl/ispa_mem.sv =====
// ----------------------------------------------------------------------------
// ispa_mem
// Single-port-write, single-port-read grid store holding all per-point arrays.
// ----------------------------------------------------------------------------
module ispa_mem (
	input  logic               clk,
	input  ispa_pkg::mem_req_t req,
	output ispa_pkg::word_t    rdata
);

	ispa_pkg::word_t mem_q [0:ispa_pkg::MDEPTH-1];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

// ===== hw/rtl/ispa_recip.sv =====
// ----------------------------------------------------------------------------
// ispa_recip
// Restoring divider: 2^40 / diag, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module ispa_recip (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ispa_pkg::word_t diag,
	output logic            done,
	output ispa_pkg::word_t recip
);

	logic                         run_q;
	logic                         done_q;
	logic [ispa_pkg::QCW-1:0]     cnt_q;
	logic [ispa_pkg::DW-1:0]      md_q;
	logic [ispa_pkg::DW-1:0]      rem_q;
	logic [ispa_pkg::QW-1:0]      quo_q;
	logic                         neg_q;
	logic                         zero_q;
	logic [ispa_pkg::DW:0]        trial;
	logic                         qbit;
	logic [ispa_pkg::QW-ispa_pkg::DW:0] qhi;

	always_comb begin
		// dividend is a single one at its top bit
		trial = {rem_q, cnt_q == '0};
		qbit  = trial >= {1'b0, md_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ispa_pkg::QCW'(ispa_pkg::QW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			md_q   <= diag[ispa_pkg::DW-1] ? ispa_pkg::DW'(-diag) : ispa_pkg::DW'(diag);
			neg_q  <= diag[ispa_pkg::DW-1];
			zero_q <= diag == '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (run_q) begin
			rem_q <= qbit ? ispa_pkg::DW'(trial - {1'b0, md_q}) : trial[ispa_pkg::DW-1:0];
			quo_q <= {quo_q[ispa_pkg::QW-2:0], qbit};
		end
	end

	always_comb begin
		qhi = quo_q[ispa_pkg::QW-1:ispa_pkg::DW-1];
		if (zero_q) begin
			recip = ispa_pkg::VMAX;
		end else if (|qhi) begin
			recip = neg_q ? ispa_pkg::VMIN : ispa_pkg::VMAX;
		end else if (neg_q) begin
			recip = ispa_pkg::word_t'(-{1'b0, quo_q[ispa_pkg::DW-2:0]});
		end else begin
			recip = ispa_pkg::word_t'({1'b0, quo_q[ispa_pkg::DW-2:0]});
		end
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/ispa_alu.sv =====
// ----------------------------------------------------------------------------
// ispa_alu
// Shared saturating multiply / add unit with accumulator and operand register.
// ----------------------------------------------------------------------------
module ispa_alu (
	input  logic                clk,
	input  ispa_pkg::alu_ctrl_t ctrl,
	input  ispa_pkg::word_t     rdata,
	output ispa_pkg::word_t     acc
);

	ispa_pkg::word_t acc_q;
	ispa_pkg::word_t b_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				ispa_pkg::AO_LDA:   acc_q <= rdata;
				ispa_pkg::AO_SUBA:  acc_q <= ispa_pkg::qsub(acc_q, rdata);
				ispa_pkg::AO_LDB:   b_q   <= rdata;
				ispa_pkg::AO_MULB:  b_q   <= ispa_pkg::qmul(b_q, rdata);
				ispa_pkg::AO_SUBB:  acc_q <= ispa_pkg::qsub(acc_q, b_q);
				ispa_pkg::AO_ADDB:  acc_q <= ispa_pkg::qadd(acc_q, b_q);
				ispa_pkg::AO_BSUBA: b_q   <= ispa_pkg::qsub(b_q, acc_q);
				ispa_pkg::AO_CLRA:  acc_q <= '0;
				default: begin
				end
			endcase
		end
	end

	assign acc = acc_q;

endmodule

// ===== hw/rtl/isai_stencil_preconditioner_apply_top.sv =====
// ----------------------------------------------------------------------------
// isai_stencil_preconditioner_apply_top
// Seven-point stencil ISAI preconditioner apply over a 16x16x16 grid, Q12.20.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; results leave as a
// one-cycle done strobe that cannot be held off. After reset the block clears
// y and z with busy high (config writes are taken any time). A load holds busy
// while the eight coefficient and rhs writes run and the 41-step reciprocal
// divider works, and the reciprocal is written when the divider raises done.
// A read returns the stored z word of the addressed point. A solve first
// clears y and z, then for each of the 2*sweep_count sweeps makes two passes
// over the active box; each point runs its micro-ops one at a time, each
// memory read going through an issue and an exec state, as the grid store has
// a single read port and there is one shared multiply/add unit.
module isai_stencil_preconditioner_apply_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [3:0]              x_pos,
	input  logic [3:0]              y_pos,
	input  logic [3:0]              z_pos,
	input  logic signed [31:0]      coef_west,
	input  logic signed [31:0]      coef_south,
	input  logic signed [31:0]      coef_down,
	input  logic signed [31:0]      coef_diag,
	input  logic signed [31:0]      coef_east,
	input  logic signed [31:0]      coef_north,
	input  logic signed [31:0]      coef_up,
	input  logic signed [31:0]      rhs_value,
	output logic                    done,
	output logic                    kind,
	output logic signed [31:0]      result_value,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [4:0]              cfg_data
);

	ispa_pkg::state_t   state_q, state_d;
	logic               clr_solve_q;
	logic [ispa_pkg::IDXW:0] clr_cnt_q;
	logic [2:0]         ld_cnt_q;
	ispa_pkg::idx_t     ld_idx_q;
	ispa_pkg::word_t    ld_val_q [0:ispa_pkg::NLD-1];
	ispa_pkg::coord_t   px_q, py_q, pz_q;
	logic               pass_q;
	logic [4:0]         swp_q;
	logic [ispa_pkg::PCW-1:0] pc_q;
	logic [3:0]         sweep_q;
	ispa_pkg::size_t_t  sx_q, sy_q, sz_q;
	logic               done_q, kind_q;
	ispa_pkg::word_t    result_q;

	ispa_pkg::size_t_t  nx, ny, nz;
	logic               empty, upper, grp_ok, skip, needs_read, last_pt, last_pass;
	logic               accept, wr_op;
	logic [4:0]         swp_last;
	ispa_pkg::uop_t     uop;
	ispa_pkg::idx_t     idx, nb_idx;
	ispa_pkg::mem_req_t mreq;
	ispa_pkg::word_t    rdata, acc, recip;
	ispa_pkg::alu_ctrl_t actl;
	logic               div_start, div_done;

	ispa_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	ispa_alu u_alu (
		.clk   (clk),
		.ctrl  (actl),
		.rdata (rdata),
		.acc   (acc)
	);

	ispa_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diag   (coef_diag),
		.done   (div_done),
		.recip  (recip)
	);

	always_comb begin
		nx = (sx_q > ispa_pkg::DIM_SZ) ? ispa_pkg::DIM_SZ : sx_q;
		ny = (sy_q > ispa_pkg::DIM_SZ) ? ispa_pkg::DIM_SZ : sy_q;
		nz = (sz_q > ispa_pkg::DIM_SZ) ? ispa_pkg::DIM_SZ : sz_q;
		empty     = (nx == '0) || (ny == '0) || (nz == '0) || (sweep_q == '0);
		upper     = swp_q >= {1'b0, sweep_q};
		uop       = ispa_pkg::uprog({upper, pass_q}, pc_q);
		idx       = {pz_q, py_q, px_q};
		accept    = start && (state_q == ispa_pkg::S_IDLE);
		swp_last  = {sweep_q, 1'b0} - 5'd1;
		last_pt   = ({1'b0, px_q} + 1'b1 >= nx) && ({1'b0, py_q} + 1'b1 >= ny)
			&& ({1'b0, pz_q} + 1'b1 >= nz);
		last_pass = pass_q && (swp_q == swp_last);
		unique case (uop.grp)
			ispa_pkg::DIR_W: begin
				grp_ok = px_q != '0;
				nb_idx = {pz_q, py_q, px_q - 1'b1};
			end
			ispa_pkg::DIR_S: begin
				grp_ok = py_q != '0;
				nb_idx = {pz_q, py_q - 1'b1, px_q};
			end
			ispa_pkg::DIR_D: begin
				grp_ok = pz_q != '0;
				nb_idx = {pz_q - 1'b1, py_q, px_q};
			end
			ispa_pkg::DIR_E: begin
				grp_ok = ({1'b0, px_q} + 1'b1) < nx;
				nb_idx = {pz_q, py_q, px_q + 1'b1};
			end
			ispa_pkg::DIR_N: begin
				grp_ok = ({1'b0, py_q} + 1'b1) < ny;
				nb_idx = {pz_q, py_q + 1'b1, px_q};
			end
			ispa_pkg::DIR_U: begin
				grp_ok = ({1'b0, pz_q} + 1'b1) < nz;
				nb_idx = {pz_q + 1'b1, py_q, px_q};
			end
			default: begin
				grp_ok = 1'b1;
				nb_idx = idx;
			end
		endcase
		skip = !grp_ok;
		case (uop.op) inside
			ispa_pkg::AO_LDA, ispa_pkg::AO_SUBA, ispa_pkg::AO_LDB, ispa_pkg::AO_MULB:
				needs_read = 1'b1;
			default: needs_read = 1'b0;
		endcase
		wr_op = uop.op == ispa_pkg::AO_WR;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ispa_pkg::S_CLR: begin
				if (&clr_cnt_q) begin
					if (!clr_solve_q) state_d = ispa_pkg::S_IDLE;
					else if (empty) state_d = ispa_pkg::S_FIN;
					else state_d = ispa_pkg::S_ISSUE;
				end
			end
			ispa_pkg::S_IDLE: begin
				if (accept) begin
					if (op == ispa_pkg::OPC_LOAD) state_d = ispa_pkg::S_LOAD;
					else if (op == ispa_pkg::OPC_SOLVE) state_d = ispa_pkg::S_CLR;
					else if (op == ispa_pkg::OPC_READ) state_d = ispa_pkg::S_READ;
				end
			end
			ispa_pkg::S_LOAD: if (&ld_cnt_q) state_d = ispa_pkg::S_DIVW;
			ispa_pkg::S_DIVW: if (div_done) state_d = ispa_pkg::S_IDLE;
			ispa_pkg::S_READ: state_d = ispa_pkg::S_IDLE;
			ispa_pkg::S_ISSUE: begin
				if (!skip && needs_read) state_d = ispa_pkg::S_EXEC;
				else if (!skip && wr_op && last_pt && last_pass) state_d = ispa_pkg::S_FIN;
			end
			ispa_pkg::S_EXEC: state_d = ispa_pkg::S_ISSUE;
			ispa_pkg::S_FIN: state_d = ispa_pkg::S_IDLE;
			default: state_d = ispa_pkg::S_IDLE;
		endcase
	end

	// outputs to memory, shared unit and divider
	always_comb begin
		mreq.we    = 1'b0;
		mreq.waddr = {ispa_pkg::ST_Z, idx};
		mreq.wdata = acc;
		mreq.raddr = {ispa_pkg::ST_Z, z_pos, y_pos, x_pos};
		actl.en    = 1'b0;
		actl.op    = uop.op;
		div_start  = 1'b0;
		unique case (state_q)
			ispa_pkg::S_CLR: begin
				mreq.we    = 1'b1;
				mreq.waddr = {clr_cnt_q[0] ? ispa_pkg::ST_Z : ispa_pkg::ST_Y,
					clr_cnt_q[ispa_pkg::IDXW:1]};
				mreq.wdata = '0;
			end
			ispa_pkg::S_IDLE: div_start = accept && (op == ispa_pkg::OPC_LOAD);
			ispa_pkg::S_LOAD: begin
				mreq.we    = 1'b1;
				mreq.waddr = {ispa_pkg::store_t'({1'b0, ld_cnt_q}), ld_idx_q};
				mreq.wdata = ld_val_q[ld_cnt_q];
			end
			ispa_pkg::S_DIVW: begin
				mreq.we    = div_done;
				mreq.waddr = {ispa_pkg::ST_RECIP, ld_idx_q};
				mreq.wdata = recip;
			end
			ispa_pkg::S_ISSUE: begin
				mreq.raddr = {uop.st, uop.nb ? nb_idx : idx};
				mreq.we    = !skip && wr_op;
				mreq.waddr = {uop.st, idx};
				actl.en    = !skip && !needs_read && !wr_op && (uop.op != ispa_pkg::AO_NOP);
			end
			ispa_pkg::S_EXEC: actl.en = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ispa_pkg::S_CLR;
			clr_solve_q <= 1'b0;
			clr_cnt_q   <= '0;
			ld_cnt_q    <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			pass_q      <= 1'b0;
			swp_q       <= '0;
			pc_q        <= '0;
			done_q      <= 1'b0;
			kind_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q   <= (state_q == ispa_pkg::S_READ) || (state_q == ispa_pkg::S_FIN);
			kind_q   <= state_q == ispa_pkg::S_READ;
			result_q <= (state_q == ispa_pkg::S_READ) ? rdata : '0;
			if (state_q == ispa_pkg::S_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == ispa_pkg::S_LOAD) ld_cnt_q <= ld_cnt_q + 1'b1;
			if (accept) begin
				clr_solve_q <= 1'b1;
				clr_cnt_q   <= '0;
				ld_cnt_q    <= '0;
				px_q        <= '0;
				py_q        <= '0;
				pz_q        <= '0;
				pass_q      <= 1'b0;
				swp_q       <= '0;
				pc_q        <= '0;
			end
			if (state_q == ispa_pkg::S_EXEC) pc_q <= pc_q + 1'b1;
			if (state_q == ispa_pkg::S_ISSUE) begin
				if (skip || (!needs_read && !wr_op)) begin
					pc_q <= pc_q + 1'b1;
				end else if (wr_op) begin
					// advance to next point, pass, sweep
					pc_q <= '0;
					if ({1'b0, px_q} + 1'b1 < nx) begin
						px_q <= px_q + 1'b1;
					end else begin
						px_q <= '0;
						if ({1'b0, py_q} + 1'b1 < ny) begin
							py_q <= py_q + 1'b1;
						end else begin
							py_q <= '0;
							if ({1'b0, pz_q} + 1'b1 < nz) begin
								pz_q <= pz_q + 1'b1;
							end else begin
								pz_q   <= '0;
								pass_q <= !pass_q;
								if (pass_q) swp_q <= swp_q + 1'b1;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 4'd1;
			sx_q    <= ispa_pkg::DIM_SZ;
			sy_q    <= ispa_pkg::DIM_SZ;
			sz_q    <= ispa_pkg::DIM_SZ;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ispa_pkg::cfg_reg_t'(cfg_index))
				ispa_pkg::CFG_SWEEP:  sweep_q <= cfg_data[3:0];
				ispa_pkg::CFG_SIZE_X: sx_q    <= cfg_data;
				ispa_pkg::CFG_SIZE_Y: sy_q    <= cfg_data;
				ispa_pkg::CFG_SIZE_Z: sz_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ld_idx_q    <= {z_pos, y_pos, x_pos};
			ld_val_q[0] <= coef_west;
			ld_val_q[1] <= coef_south;
			ld_val_q[2] <= coef_down;
			ld_val_q[3] <= coef_diag;
			ld_val_q[4] <= coef_east;
			ld_val_q[5] <= coef_north;
			ld_val_q[6] <= coef_up;
			ld_val_q[7] <= rhs_value;
		end
	end

	assign busy         = state_q != ispa_pkg::S_IDLE;
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign kind         = kind_q;
	assign result_value = result_q;

endmodule

// ===== hw/rtl/ispa_chk.sv =====
// ----------------------------------------------------------------------------
// ispa_chk
// Port-level checks on commands, result timing and solve words, bound to the top level.
// ----------------------------------------------------------------------------
module ispa_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         op,
	input logic               done,
	input logic               kind,
	input logic signed [31:0] result_value
);

	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !kind |-> result_value == '0)
		else $error("solve word carries nonzero value");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == ispa_pkg::OPC_LOAD || op == ispa_pkg::OPC_SOLVE
			|| op == ispa_pkg::OPC_READ) |=> busy)
		else $error("accepted command did not raise busy");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !(op == ispa_pkg::OPC_LOAD || op == ispa_pkg::OPC_SOLVE
			|| op == ispa_pkg::OPC_READ) |=> !busy)
		else $error("unknown command not dropped");

	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result word longer than one cycle");

endmodule

bind isai_stencil_preconditioner_apply_top ispa_chk u_ispa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.done         (done),
	.kind         (kind),
	.result_value (result_value)
);

// ===== tb/tb_isai_stencil_preconditioner_apply_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_isai_stencil_preconditioner_apply_top
// Drives load, solve and read commands into the stencil preconditioner over a
// range of sweep counts and box shapes, predicts every solve-done and read word
// with a Q12.20 fixed-point model of the sweeps, and checks each done strobe.
// ----------------------------------------------------------------------------
module tb_isai_stencil_preconditioner_apply_top;
	import ispa_pkg::*;

	localparam int        NPT       = 4096;
	localparam longint    CYC_LIMIT = 8000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int        Q_MAX     = 32'h7fffffff;
	localparam int        Q_MIN     = 32'h80000000;

	typedef struct {
		logic [1:0] op;
		logic [3:0] px, py, pz;
		int         cw, cs, cd, cg, ce, cn, cu, rhs;
	} cmd_t;

	typedef struct {
		logic k;
		int   v;
	} word_exp_t;

	typedef struct {
		cfg_reg_t   idx;
		logic [4:0] val;
	} cfg_wr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = '0;
	logic [3:0]  x_pos = '0, y_pos = '0, z_pos = '0;
	logic signed [31:0] coef_west = '0, coef_south = '0, coef_down = '0, coef_diag = '0;
	logic signed [31:0] coef_east = '0, coef_north = '0, coef_up = '0, rhs_value = '0;
	logic        done, kind;
	logic signed [31:0] result_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;

	isai_stencil_preconditioner_apply_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos),
		.coef_west(coef_west), .coef_south(coef_south), .coef_down(coef_down),
		.coef_diag(coef_diag), .coef_east(coef_east), .coef_north(coef_north),
		.coef_up(coef_up), .rhs_value(rhs_value),
		.done(done), .kind(kind), .result_value(result_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	int   g_west[NPT], g_south[NPT], g_down[NPT], g_diag[NPT], g_east[NPT];
	int   g_north[NPT], g_up[NPT], g_rhs[NPT], g_recip[NPT];
	int   g_y[NPT], g_res[NPT], g_z[NPT];
	logic [3:0] m_sweeps = 4'd1;
	logic [4:0] m_sx = 5'd16, m_sy = 5'd16, m_sz = 5'd16;

	cmd_t      pend_cmds[$];
	word_exp_t exp_words[$];
	cfg_wr_t   pend_cfg[$];
	cmd_t      cur;
	int        gap_left = 0;
	bit        no_idle = 0;
	int        mismatches = 0, n_loads = 0, n_solves = 0, n_reads = 0, n_words = 0;
	longint    cycles = 0;

	function automatic int sat32(longint v);
		if (v > longint'(Q_MAX)) return Q_MAX;
		if (v < longint'(Q_MIN)) return Q_MIN;
		return int'(v);
	endfunction

	function automatic int fx_add(int a, int b);
		return sat32(longint'(a) + longint'(b));
	endfunction

	function automatic int fx_sub(int a, int b);
		return sat32(longint'(a) - longint'(b));
	endfunction

	// floor shift of the exact product
	function automatic int fx_mul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b);
		return sat32(p >>> FRAC);
	endfunction

	function automatic int fx_recip(int d);
		longint md, q;
		if (d == 0) return Q_MAX;
		md = (d < 0) ? -longint'(d) : longint'(d);
		q = (longint'(1) << 40) / md;
		return (d < 0) ? sat32(-q) : sat32(q);
	endfunction

	function automatic int box_dim(logic [4:0] s);
		return (s > 5'd16) ? 16 : int'(s);
	endfunction

	// coef * v[nb] * recip[nb], zero outside the box
	function automatic int nb_term(bit inb, int c, int v, int nb);
		return inb ? fx_mul(fx_mul(c, v), g_recip[nb]) : 0;
	endfunction

	task automatic run_sweeps();
		int nx, ny, nz, i, acc, t;
		bit upper, bw, bs, bd, be, bn, bu;
		nx = box_dim(m_sx);
		ny = box_dim(m_sy);
		nz = box_dim(m_sz);
		for (int k = 0; k < NPT; k++) begin
			g_y[k] = 0;
			g_z[k] = 0;
		end
		for (int s = 0; s < 2 * int'(m_sweeps); s++) begin
			upper = s >= int'(m_sweeps);
			for (int pass = 0; pass < 2; pass++)
				for (int z = 0; z < nz; z++)
					for (int y = 0; y < ny; y++)
						for (int x = 0; x < nx; x++) begin
							i = (z * 16 + y) * 16 + x;
							if (!upper) begin
								bw = x > 0; bs = y > 0; bd = z > 0;
								if (pass == 0) begin
									acc = fx_sub(g_rhs[i], g_y[i]);
									acc = fx_sub(acc, nb_term(bw, g_west[i], bw ? g_y[i-1] : 0, bw ? i-1 : i));
									acc = fx_sub(acc, nb_term(bs, g_south[i], bs ? g_y[i-16] : 0, bs ? i-16 : i));
									acc = fx_sub(acc, nb_term(bd, g_down[i], bd ? g_y[i-256] : 0, bd ? i-256 : i));
									g_res[i] = acc;
								end else begin
									acc = g_res[i];
									acc = fx_sub(acc, nb_term(bw, g_west[i], bw ? g_res[i-1] : 0, bw ? i-1 : i));
									acc = fx_sub(acc, nb_term(bs, g_south[i], bs ? g_res[i-16] : 0, bs ? i-16 : i));
									acc = fx_sub(acc, nb_term(bd, g_down[i], bd ? g_res[i-256] : 0, bd ? i-256 : i));
									g_y[i] = fx_add(g_y[i], acc);
								end
							end else begin
								be = x + 1 < nx; bn = y + 1 < ny; bu = z + 1 < nz;
								if (pass == 0) begin
									acc = fx_sub(g_y[i], fx_mul(g_z[i], g_diag[i]));
									if (be) acc = fx_sub(acc, fx_mul(g_east[i], g_z[i+1]));
									if (bn) acc = fx_sub(acc, fx_mul(g_north[i], g_z[i+16]));
									if (bu) acc = fx_sub(acc, fx_mul(g_up[i], g_z[i+256]));
									g_res[i] = acc;
								end else begin
									t = nb_term(be, g_east[i], be ? g_res[i+1] : 0, be ? i+1 : i);
									t = fx_add(t, nb_term(bn, g_north[i], bn ? g_res[i+16] : 0, bn ? i+16 : i));
									t = fx_add(t, nb_term(bu, g_up[i], bu ? g_res[i+256] : 0, bu ? i+256 : i));
									acc = fx_mul(g_recip[i], fx_sub(g_res[i], t));
									g_z[i] = fx_add(g_z[i], acc);
								end
							end
						end
		end
	endtask

	task automatic apply_cmd(cmd_t c);
		int i;
		word_exp_t e;
		i = int'({c.pz, c.py, c.px});
		if (c.op == OPC_LOAD) begin
			g_west[i] = c.cw; g_south[i] = c.cs; g_down[i] = c.cd; g_diag[i] = c.cg;
			g_east[i] = c.ce; g_north[i] = c.cn; g_up[i] = c.cu; g_rhs[i] = c.rhs;
			g_recip[i] = fx_recip(c.cg);
			n_loads++;
		end else if (c.op == OPC_SOLVE) begin
			run_sweeps();
			e.k = 1'b0; e.v = 0;
			exp_words.push_back(e);
			n_solves++;
		end else if (c.op == OPC_READ) begin
			e.k = 1'b1; e.v = g_z[i];
			exp_words.push_back(e);
			n_reads++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 100);
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// command and register write driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (start && !busy) apply_cmd(cur);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pend_cmds.size() > 0) begin
					cur = pend_cmds.pop_front();
					op <= cur.op;
					x_pos <= cur.px; y_pos <= cur.py; z_pos <= cur.pz;
					coef_west <= cur.cw; coef_south <= cur.cs; coef_down <= cur.cd;
					coef_diag <= cur.cg; coef_east <= cur.ce; coef_north <= cur.cn;
					coef_up <= cur.cu; rhs_value <= cur.rhs;
					start <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SWEEP:  m_sweeps = cfg_data[3:0];
					CFG_SIZE_X: m_sx = cfg_data;
					CFG_SIZE_Y: m_sy = cfg_data;
					CFG_SIZE_Z: m_sz = cfg_data;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (pend_cfg.size() > 0) begin
					cfg_wr_t w;
					w = pend_cfg.pop_front();
					cfg_index <= w.idx;
					cfg_data  <= w.val;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && done) begin
			word_exp_t e;
			n_words++;
			if (exp_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d value %0d", kind, result_value);
			end else begin
				e = exp_words.pop_front();
				if (kind !== e.k || result_value !== e.v) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d value %0d, got kind %0d value %0d",
							e.k, e.v, kind, result_value);
				end
			end
		end
	end

	function automatic int rnd_coef();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return int'($urandom());
		if (r == 1) begin
			case ($urandom_range(0, 4))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		return int'($urandom_range(0, 1 << 20)) - (1 << 19);
	endfunction

	function automatic int rnd_diag();
		int r, m;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return int'($urandom());
		m = int'($urandom_range(1 << 19, 1 << 22));
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	function automatic cmd_t mk_cmd(logic [1:0] o, int x, int y, int z);
		cmd_t c;
		c.op = o; c.px = 4'(x); c.py = 4'(y); c.pz = 4'(z);
		c.cw = rnd_coef(); c.cs = rnd_coef(); c.cd = rnd_coef(); c.cg = rnd_diag();
		c.ce = rnd_coef(); c.cn = rnd_coef(); c.cu = rnd_coef();
		c.rhs = $urandom_range(0, 7) == 0 ? int'($urandom()) : rnd_coef();
		return c;
	endfunction

	task automatic wait_idle();
		while (pend_cmds.size() > 0 || pend_cfg.size() > 0 || start || cfg_valid ||
			exp_words.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_config(int sw, int sx, int sy, int sz);
		cfg_wr_t w;
		wait_idle();
		w.idx = CFG_SWEEP;  w.val = {1'($urandom_range(0, 1)), 4'(sw)}; pend_cfg.push_back(w);
		w.idx = CFG_SIZE_X; w.val = 5'(sx); pend_cfg.push_back(w);
		w.idx = CFG_SIZE_Y; w.val = 5'(sy); pend_cfg.push_back(w);
		w.idx = CFG_SIZE_Z; w.val = 5'(sz); pend_cfg.push_back(w);
		wait_idle();
	endtask

	// fill every point of the active box so a solve never reads an unwritten entry
	task automatic load_box();
		for (int z = 0; z < box_dim(m_sz); z++)
			for (int y = 0; y < box_dim(m_sy); y++)
				for (int x = 0; x < box_dim(m_sx); x++)
					pend_cmds.push_back(mk_cmd(OPC_LOAD, x, y, z));
	endtask

	task automatic random_phase(int n_items);
		int nx, ny, nz, r, x, y, z;
		nx = box_dim(m_sx); ny = box_dim(m_sy); nz = box_dim(m_sz);
		no_idle = $urandom_range(0, 3) == 0;
		load_box();
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0 || nx == 0 || ny == 0 || nz == 0) begin
				x = $urandom_range(0, 15); y = $urandom_range(0, 15); z = $urandom_range(0, 15);
			end else begin
				x = $urandom_range(0, nx - 1); y = $urandom_range(0, ny - 1);
				z = $urandom_range(0, nz - 1);
			end
			if (r < 3) pend_cmds.push_back(mk_cmd(OPC_SOLVE, x, y, z));
			else if (r < 5) pend_cmds.push_back(mk_cmd(OP_UNUSED, x, y, z));
			else if (r < 58) pend_cmds.push_back(mk_cmd(OPC_LOAD, x, y, z));
			else pend_cmds.push_back(mk_cmd(OPC_READ, x, y, z));
		end
		pend_cmds.push_back(mk_cmd(OPC_SOLVE, 0, 0, 0));
		for (int k = 0; k < 6; k++)
			pend_cmds.push_back(mk_cmd(OPC_READ, $urandom_range(0, nx > 0 ? nx - 1 : 15),
				$urandom_range(0, ny > 0 ? ny - 1 : 15), $urandom_range(0, nz > 0 ? nz - 1 : 15)));
	endtask

	initial begin
		cmd_t c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 2x2x2 box, two sweeps, extreme coefficients
		set_config(2, 2, 2, 2);
		for (int k = 0; k < 8; k++) begin
			c = mk_cmd(OPC_LOAD, k & 1, (k >> 1) & 1, k >> 2);
			case (k)
				0: c.cg = 0;
				1: c.cg = Q_MIN;
				2: c.cg = 1;
				3: begin
					c.cw = Q_MAX; c.cs = Q_MAX; c.cd = Q_MAX; c.cg = Q_MAX;
					c.ce = Q_MAX; c.cn = Q_MAX; c.cu = Q_MAX; c.rhs = Q_MAX;
				end
				4: begin
					c.cw = Q_MIN; c.cs = Q_MIN; c.cd = Q_MIN; c.cg = Q_MIN;
					c.ce = Q_MIN; c.cn = Q_MIN; c.cu = Q_MIN; c.rhs = Q_MIN;
				end
				5: c.cg = -1;
				default: ;
			endcase
			pend_cmds.push_back(c);
		end
		pend_cmds.push_back(mk_cmd(OPC_READ, 15, 15, 15));
		pend_cmds.push_back(mk_cmd(OPC_LOAD, 15, 15, 15));
		pend_cmds.push_back(mk_cmd(OP_UNUSED, 0, 0, 0));
		pend_cmds.push_back(mk_cmd(OPC_SOLVE, 0, 0, 0));
		for (int k = 0; k < 8; k++)
			pend_cmds.push_back(mk_cmd(OPC_READ, k & 1, (k >> 1) & 1, k >> 2));
		pend_cmds.push_back(mk_cmd(OPC_READ, 15, 15, 15));

		// corner settings: most sweeps, no sweeps, each axis at full length, empty box
		set_config(15, 2, 2, 1);  random_phase(90);
		set_config(0, 3, 3, 3);   random_phase(90);
		set_config(1, 16, 1, 1);  random_phase(90);
		set_config(1, 1, 31, 1);  random_phase(90);
		set_config(1, 1, 1, 16);  random_phase(90);
		set_config(3, 0, 4, 4);   random_phase(90);
		set_config(2, 17, 0, 20); random_phase(60);
		for (int p = 0; p < 8; p++) begin
			set_config($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
				$urandom_range(1, 3));
			random_phase(90);
		end

		wait_idle();
		repeat (100) @(posedge clk);
		$display("covered %0d loads, %0d solves, %0d reads; %0d result words in %0d cycles",
			n_loads, n_solves, n_reads, n_words, cycles);
		if (mismatches == 0 && exp_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d words never seen", mismatches, exp_words.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== isai_stencil_preconditioner_apply_top.f =====
hw/rtl/ispa_pkg.sv
hw/rtl/ispa_mem.sv
hw/rtl/ispa_recip.sv
hw/rtl/ispa_alu.sv
hw/rtl/isai_stencil_preconditioner_apply_top.sv
hw/rtl/ispa_chk.sv
tb/tb_isai_stencil_preconditioner_apply_top.sv
